/* src/srlm_pkg.sv */
package srlm_pkg;

  // Tick counter width; a wait ends with a timeout when it would reach 2^COUNT_BITS.
  localparam int COUNT_BITS = 16;

  localparam int THR_W      = 10;
  localparam int TICK_W     = 8;
  localparam int SAMPLE_W   = 10;
  localparam int LAT_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // ms result = (count * tick_us + ROUND_OFS) / 1000, saturated at LAT_SAT
  localparam int ROUND_OFS  = 500;
  localparam int LAT_SAT    = 16383;
  localparam int SAT_X      = (LAT_SAT + 1) * 1000;

  // Numerator width before saturation
  localparam int X_W        = COUNT_BITS + TICK_W + 1;
  // Below SAT_X the numerator fits in DIV_IN_W bits
  localparam int DIV_IN_W   = 24;
  localparam int CMP_W      = (X_W > DIV_IN_W + 1) ? X_W : DIV_IN_W + 1;

  // x / 1000 = (x >> 3) / 125, the latter by reciprocal multiply
  localparam int DIV_Y_W      = DIV_IN_W - 3;
  localparam int RECIP_SHIFT  = 28;
  localparam int RECIP_W      = 22;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(2147484);
  localparam int QPROD_W      = DIV_Y_W + RECIP_W;

  typedef enum logic [1:0] {
    STATUS_MEASURED = 2'd0,
    STATUS_TIMEOUT  = 2'd1,
    STATUS_ABORT    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESP_THR = 3'd0,
    CFG_RISING   = 3'd1,
    CFG_TRIG_EN  = 3'd2,
    CFG_TRIG_THR = 3'd3,
    CFG_KEY_THR  = 3'd4,
    CFG_TICK_US  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  typedef struct packed {
    logic [THR_W-1:0]  resp_thr;
    logic              rising;
    logic              trig_en;
    logic [THR_W-1:0]  trig_thr;
    logic [THR_W-1:0]  key_thr;
    logic [TICK_W-1:0] tick_us;
  } cfg_t;

  // Outcome of one request, before the latency conversion
  typedef struct packed {
    logic                  stimulus;
    logic                  done;
    status_e               status;
    logic                  measured;
    logic [COUNT_BITS-1:0] count;
  } res_t;

endpackage

/* src/stimulus_response_latency_meter_core.sv */
// Stimulus-to-response latency meter, one request per converter sample set.
//
// Channels (valid/ready, a request moves when both are high):
//   config : cfg_index_i selects the register (0 response threshold,
//            1 rising polarity, 2 trigger enable, 3 trigger threshold,
//            4 key threshold, 5 tick_us), cfg_data_i carries the value.
//            Always ready; write only while no request is in flight.
//   input  : action_i (0 start, 1 tick) plus the three 10-bit samples.
//   output : one result per input request: stimulus_on_o, done_res_o,
//            status_o (0 measured, 1 timeout, 2 key abort), latency_ms_o.
// Path: each result passes the ctrl result register, then conversion stages 2, 3 and 4.
// Throughput: one request per cycle unless stalled; the tick counter and phase update
//   in the accept cycle, the ms conversion (multiply, reciprocal divide
//   by 1000) runs in three registered stages behind it.
// Stall: the whole pipe freezes while the output is held; in_ready_o
//   drops only when the output register is full and not taken.
// Reset: registers return to defaults, phase idle, stimulus off,
//   pipe empty.
module stimulus_response_latency_meter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srlm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input requests
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [srlm_pkg::SAMPLE_W-1:0]   sensor_sample_i,
  input  logic [srlm_pkg::SAMPLE_W-1:0]   trigger_sample_i,
  input  logic [srlm_pkg::SAMPLE_W-1:0]   key_level_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            stimulus_on_o,
  output logic                            done_res_o,
  output logic [1:0]                      status_o,
  output logic [srlm_pkg::LAT_W-1:0]      latency_ms_o
);

  srlm_pkg::cfg_t    cfg;
  srlm_pkg::res_t    res;
  srlm_pkg::status_e status;
  logic              res_valid;
  logic              pipe_en;   // advance every stage together
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign pipe_en     = !out_valid_o || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign accept      = in_valid_i && pipe_en;

  srlm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // phase, tick counter and stimulus; first pipe register
  srlm_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .en_i             (pipe_en),
    .accept_i         (accept),
    .action_i         (action_i),
    .sensor_sample_i  (sensor_sample_i),
    .trigger_sample_i (trigger_sample_i),
    .key_level_i      (key_level_i),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // count -> rounded ms, saturating
  srlm_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .tick_us_i   (cfg.tick_us),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .stimulus_o  (stimulus_on_o),
    .done_o      (done_res_o),
    .status_o    (status),
    .latency_o   (latency_ms_o)
  );

  assign status_o = status;

  // Nothing finishes without a start having raised the stimulus.
  a_done_needs_stim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> stimulus_on_o)
    else $error("measurement finished with stimulus off");

  // An unfinished result carries neither status nor latency.
  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == 2'd0 && latency_ms_o == '0)
    else $error("status or latency set on unfinished result");

  // Aborts and timeouts report zero latency.
  a_fail_zero_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && status_o != 2'd0 |-> latency_ms_o == '0)
    else $error("nonzero latency on abort or timeout");

endmodule

/* src/srlm_cfg_regs.sv */
module srlm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_i,
  input  logic [srlm_pkg::CFG_IDX_W-1:0]   index_i,
  input  logic [srlm_pkg::CFG_DATA_W-1:0]  data_i,
  output srlm_pkg::cfg_t                   cfg_o
);

  srlm_pkg::cfg_t cfg_q;
  srlm_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (srlm_pkg::cfg_idx_e'(index_i))
        srlm_pkg::CFG_RESP_THR: cfg_d.resp_thr = data_i[srlm_pkg::THR_W-1:0];
        srlm_pkg::CFG_RISING:   cfg_d.rising   = data_i[0];
        srlm_pkg::CFG_TRIG_EN:  cfg_d.trig_en  = data_i[0];
        srlm_pkg::CFG_TRIG_THR: cfg_d.trig_thr = data_i[srlm_pkg::THR_W-1:0];
        srlm_pkg::CFG_KEY_THR:  cfg_d.key_thr  = data_i[srlm_pkg::THR_W-1:0];
        srlm_pkg::CFG_TICK_US:  cfg_d.tick_us  = data_i[srlm_pkg::TICK_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resp_thr <= srlm_pkg::THR_W'(512);
      cfg_q.rising   <= 1'b0;
      cfg_q.trig_en  <= 1'b0;
      cfg_q.trig_thr <= srlm_pkg::THR_W'(512);
      cfg_q.key_thr  <= srlm_pkg::THR_W'(1000);
      cfg_q.tick_us  <= srlm_pkg::TICK_W'(64);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/srlm_ctrl.sv */
module srlm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srlm_pkg::cfg_t                  cfg_i,
  input  logic                            en_i,
  input  logic                            accept_i,
  input  logic                            action_i,
  input  logic [srlm_pkg::SAMPLE_W-1:0]   sensor_sample_i,
  input  logic [srlm_pkg::SAMPLE_W-1:0]   trigger_sample_i,
  input  logic [srlm_pkg::SAMPLE_W-1:0]   key_level_i,
  output logic                            res_valid_o,
  output srlm_pkg::res_t                  res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RESP = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [srlm_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic                            stim_q, stim_d;
  logic                            res_valid_q;
  srlm_pkg::res_t                  res_q, res_d;
  logic                            hit;

  always_comb begin
    phase_d         = phase_q;
    count_d         = count_q;
    stim_d          = stim_q;
    hit             = 1'b0;
    res_d.done      = 1'b0;
    res_d.status    = srlm_pkg::STATUS_MEASURED;
    res_d.measured  = 1'b0;
    res_d.count     = count_q;

    if (srlm_pkg::action_e'(action_i) == srlm_pkg::ACT_START) begin
      stim_d  = 1'b1;
      count_d = '0;
      phase_d = cfg_i.trig_en ? PH_TRIG : PH_RESP;
    end else begin
      case (phase_q)
        PH_TRIG, PH_RESP: begin
          if (phase_q == PH_TRIG) begin
            hit = trigger_sample_i > cfg_i.trig_thr;
          end else if (cfg_i.rising) begin
            hit = sensor_sample_i > cfg_i.resp_thr;
          end else begin
            hit = sensor_sample_i < cfg_i.resp_thr;
          end

          if (hit && phase_q == PH_TRIG) begin
            // armed: restart timing
            count_d = '0;
            phase_d = PH_RESP;
          end else if (hit) begin
            res_d.done     = 1'b1;
            res_d.measured = 1'b1;
            phase_d        = PH_IDLE;
          end else if (key_level_i < cfg_i.key_thr) begin
            res_d.done   = 1'b1;
            res_d.status = srlm_pkg::STATUS_ABORT;
            phase_d      = PH_IDLE;
          end else if (&count_q) begin
            // count would wrap; it is cleared, and no later result uses it
            res_d.done   = 1'b1;
            res_d.status = srlm_pkg::STATUS_TIMEOUT;
            count_d      = '0;
            phase_d      = PH_IDLE;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    res_d.stimulus = stim_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      stim_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (accept_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
        stim_q  <= stim_d;
      end
      if (en_i) begin
        res_valid_q <= accept_i;
        res_q       <= res_d;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* src/srlm_conv.sv */
module srlm_conv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [srlm_pkg::TICK_W-1:0]   tick_us_i,
  input  logic                          res_valid_i,
  input  srlm_pkg::res_t                res_i,
  output logic                          out_valid_o,
  output logic                          stimulus_o,
  output logic                          done_o,
  output srlm_pkg::status_e             status_o,
  output logic [srlm_pkg::LAT_W-1:0]    latency_o
);

  typedef struct packed {
    logic              stimulus;
    logic              done;
    srlm_pkg::status_e status;
    logic              measured;
  } flags_t;

  // stage 2: rounded numerator
  logic                          s2_valid_q;
  flags_t                        s2_flags_q;
  logic [srlm_pkg::X_W-1:0]      s2_x_q, s2_x_d;
  // stage 3: saturation flag and reciprocal product
  logic                          s3_valid_q;
  flags_t                        s3_flags_q;
  logic                          s3_sat_q, s3_sat_d;
  logic [srlm_pkg::QPROD_W-1:0]  s3_prod_q, s3_prod_d;
  // stage 4: output register
  logic                          s4_valid_q;
  flags_t                        s4_flags_q;
  logic [srlm_pkg::LAT_W-1:0]    s4_lat_q, s4_lat_d;

  logic [srlm_pkg::CMP_W-1:0]    x_ext;
  logic [srlm_pkg::DIV_Y_W-1:0]  y;
  flags_t                        s1_flags;

  assign s1_flags = '{stimulus: res_i.stimulus, done: res_i.done,
                      status: res_i.status, measured: res_i.measured};

  assign s2_x_d = srlm_pkg::X_W'(res_i.count) * srlm_pkg::X_W'(tick_us_i)
                + srlm_pkg::X_W'(srlm_pkg::ROUND_OFS);

  assign x_ext     = srlm_pkg::CMP_W'(s2_x_q);
  assign s3_sat_d  = x_ext >= srlm_pkg::CMP_W'(srlm_pkg::SAT_X);
  assign y         = x_ext[srlm_pkg::DIV_IN_W-1:3];
  assign s3_prod_d = srlm_pkg::QPROD_W'(y) * srlm_pkg::QPROD_W'(srlm_pkg::RECIP);

  always_comb begin
    if (!s3_flags_q.measured) begin
      s4_lat_d = '0;
    end else if (s3_sat_q) begin
      s4_lat_d = srlm_pkg::LAT_W'(srlm_pkg::LAT_SAT);
    end else begin
      s4_lat_d = s3_prod_q[srlm_pkg::RECIP_SHIFT +: srlm_pkg::LAT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= res_valid_i;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_flags_q <= s1_flags;
      s2_x_q     <= s2_x_d;
      s3_flags_q <= s2_flags_q;
      s3_sat_q   <= s3_sat_d;
      s3_prod_q  <= s3_prod_d;
      s4_flags_q <= s3_flags_q;
      s4_lat_q   <= s4_lat_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign stimulus_o  = s4_flags_q.stimulus;
  assign done_o      = s4_flags_q.done;
  assign status_o    = s4_flags_q.status;
  assign latency_o   = s4_lat_q;

endmodule

/* bench/stimulus_response_latency_meter_core_tb.sv */
module stimulus_response_latency_meter_core_tb;

  localparam int IDLE_PCT     = 18;    // chance per cycle that a side sits out
  localparam int STEADY_ITEMS = 80;    // size of the stretch with no idling
  localparam int RANDOM_ITEMS = 450;   // size of the random part
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int PIPE_CYCLES  = 3;     // scales the final idle wait
  localparam int MS_DIV       = 1000;

  typedef logic [srlm_pkg::SAMPLE_W-1:0]   sample_t;
  typedef logic [srlm_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // Measurement phase as the meter tracks it
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG_WAIT,
    PH_RESP_WAIT
  } meter_phase_e;

  // One expected result
  typedef struct packed {
    logic                       stimulus;
    logic                       done;
    srlm_pkg::status_e          status;
    logic [srlm_pkg::LAT_W-1:0] latency;
  } meter_report_t;

  // Shadow of the meter: registers, phase, tick count, stimulus level,
  // plus the reports still owed by the block.
  class latency_tracker;
    srlm_pkg::cfg_t regs;
    meter_phase_e   phase;
    int unsigned    ticks;
    logic           stim;
    meter_report_t  pending_reports[$];
    int unsigned    errors;

    function new();
      regs = '{resp_thr: 10'd512, rising: 1'b0, trig_en: 1'b0, trig_thr: 10'd512,
               key_thr: 10'd1000, tick_us: 8'd64};
      phase  = PH_IDLE;
      ticks  = 0;
      stim   = 1'b0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

    function void set_reg(srlm_pkg::cfg_idx_e idx, cfg_data_t d);
      case (idx)
        srlm_pkg::CFG_RESP_THR: regs.resp_thr = d[srlm_pkg::THR_W-1:0];
        srlm_pkg::CFG_RISING:   regs.rising   = d[0];
        srlm_pkg::CFG_TRIG_EN:  regs.trig_en  = d[0];
        srlm_pkg::CFG_TRIG_THR: regs.trig_thr = d[srlm_pkg::THR_W-1:0];
        srlm_pkg::CFG_KEY_THR:  regs.key_thr  = d[srlm_pkg::THR_W-1:0];
        srlm_pkg::CFG_TICK_US:  regs.tick_us  = d[srlm_pkg::TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // rounded ms, clamped to the output range
    function logic [srlm_pkg::LAT_W-1:0] count_to_ms(int unsigned count);
      longint unsigned num;
      num = 64'(count);
      num = (num * 64'(regs.tick_us) + 64'(srlm_pkg::ROUND_OFS)) / 64'(MS_DIV);
      if (num > 64'(srlm_pkg::LAT_SAT)) num = 64'(srlm_pkg::LAT_SAT);
      return num[srlm_pkg::LAT_W-1:0];
    endfunction

    function void take_request(srlm_pkg::action_e act, sample_t sensor, sample_t trig,
                               sample_t key);
      meter_report_t rep;
      int unsigned   limit;
      int unsigned   c;
      logic          hit;
      limit       = 1 << srlm_pkg::COUNT_BITS;
      c           = ticks % limit;
      rep.done    = 1'b0;
      rep.status  = srlm_pkg::STATUS_MEASURED;
      rep.latency = '0;
      if (act == srlm_pkg::ACT_START) begin
        stim  = 1'b1;
        ticks = 0;
        phase = regs.trig_en ? PH_TRIG_WAIT : PH_RESP_WAIT;
      end else if (phase != PH_IDLE) begin
        if (phase == PH_TRIG_WAIT) hit = trig > regs.trig_thr;
        else if (regs.rising) hit = sensor > regs.resp_thr;
        else hit = sensor < regs.resp_thr;
        if (hit && phase == PH_TRIG_WAIT) begin
          ticks = 0;
          phase = PH_RESP_WAIT;
        end else if (hit) begin
          rep.done    = 1'b1;
          rep.latency = count_to_ms(c);
          ticks       = c;
          phase       = PH_IDLE;
        end else if (key < regs.key_thr) begin
          rep.done   = 1'b1;
          rep.status = srlm_pkg::STATUS_ABORT;
          phase      = PH_IDLE;
        end else if (c + 1 >= limit) begin
          rep.done   = 1'b1;
          rep.status = srlm_pkg::STATUS_TIMEOUT;
          ticks      = limit;
          phase      = PH_IDLE;
        end else begin
          ticks = c + 1;
        end
      end
      rep.stimulus = stim;
      pending_reports.push_back(rep);
    endfunction

    function void check_result(logic stim_seen, logic done_seen, logic [1:0] status_seen,
                               logic [srlm_pkg::LAT_W-1:0] lat_seen);
      meter_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result (stim %0d done %0d status %0d latency %0d)",
                 $time, stim_seen, done_seen, status_seen, lat_seen);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (want.stimulus !== stim_seen) begin
        $display("%0t: stimulus_on expected %0d actual %0d", $time, want.stimulus, stim_seen);
        errors++;
      end
      if (want.done !== done_seen) begin
        $display("%0t: done_res expected %0d actual %0d", $time, want.done, done_seen);
        errors++;
      end
      if (want.status !== status_seen) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status_seen);
        errors++;
      end
      if (want.latency !== lat_seen) begin
        $display("%0t: latency_ms expected %0d actual %0d", $time, want.latency, lat_seen);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [srlm_pkg::CFG_IDX_W-1:0]  cfg_index;
  cfg_data_t                       cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  srlm_pkg::action_e               action;
  sample_t                         sensor;
  sample_t                         trigger;
  sample_t                         key_lvl;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            stim_on;
  logic                            done_res;
  logic [1:0]                      status;
  logic [srlm_pkg::LAT_W-1:0]      latency;

  latency_tracker tracker;
  int             gap_pct;          // sender idle chance, zeroed for the steady stretch
  bit             rx_steady;        // receiver never stalls while set
  int unsigned    n_items;
  int unsigned    quiet_cycles = 0;

  stimulus_response_latency_meter_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .sensor_sample_i  (sensor),
    .trigger_sample_i (trigger),
    .key_level_i      (key_lvl),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .stimulus_on_o    (stim_on),
    .done_res_o       (done_res),
    .status_o         (status),
    .latency_ms_o     (latency)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, checked on every handshake.
  always @(posedge clk_i) begin
    out_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      tracker.check_result(stim_on, done_res, status, latency);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request; valid stays up after the handshake so back-to-back
  // requests never drop it. Callers that pause go through settle().
  task automatic send_req(srlm_pkg::action_e act, sample_t s, sample_t t, sample_t k);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    sensor   <= s;
    trigger  <= t;
    key_lvl  <= k;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    tracker.take_request(act, s, t, k);
    n_items++;
  endtask

  // Stop sending and let every owed result come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register write; only called with the meter drained.
  task automatic write_reg(srlm_pkg::cfg_idx_e idx, cfg_data_t d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    tracker.set_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_t any_sample();
    return sample_t'($urandom_range(1023));
  endfunction

  // Threshold pick, biased toward the ends of the range
  function automatic sample_t pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return sample_t'($urandom_range(1023));
    endcase
  endfunction

  // Response sample that does or does not cross; random when the
  // threshold leaves no crossing value.
  function automatic sample_t pick_resp(bit hit);
    int unsigned thr;
    thr = 32'(tracker.regs.resp_thr);
    if (tracker.regs.rising) begin
      if (!hit) return sample_t'($urandom_range(thr, 0));
      return (thr == 1023) ? any_sample() : sample_t'($urandom_range(1023, thr + 1));
    end
    if (!hit) return sample_t'($urandom_range(1023, thr));
    return (thr == 0) ? any_sample() : sample_t'($urandom_range(thr - 1, 0));
  endfunction

  function automatic sample_t pick_trig(bit arm);
    int unsigned thr;
    thr = 32'(tracker.regs.trig_thr);
    if (!arm) return sample_t'($urandom_range(thr, 0));
    return (thr == 1023) ? any_sample() : sample_t'($urandom_range(1023, thr + 1));
  endfunction

  function automatic sample_t pick_key(bit abort);
    int unsigned thr;
    thr = 32'(tracker.regs.key_thr);
    if (!abort) return sample_t'($urandom_range(1023, thr));
    return (thr == 0) ? any_sample() : sample_t'($urandom_range(thr - 1, 0));
  endfunction

  task automatic random_config();
    write_reg(srlm_pkg::CFG_RESP_THR, pick_level());
    write_reg(srlm_pkg::CFG_RISING, cfg_data_t'($urandom_range(1)));
    write_reg(srlm_pkg::CFG_TRIG_EN, cfg_data_t'($urandom_range(1)));
    write_reg(srlm_pkg::CFG_TRIG_THR, pick_level());
    write_reg(srlm_pkg::CFG_KEY_THR, pick_level());
    case ($urandom_range(3))
      0:       write_reg(srlm_pkg::CFG_TICK_US, 10'd1);
      1:       write_reg(srlm_pkg::CFG_TICK_US, 10'd128);
      default: write_reg(srlm_pkg::CFG_TICK_US, cfg_data_t'($urandom_range(128, 1)));
    endcase
  endtask

  // Mostly a full measurement with random content: start, arm if the
  // trigger is on, some quiet ticks, then a crossing. The rest is noise,
  // aborts and restarts. No drain pauses while the sender runs steady.
  task automatic run_sequence();
    int unsigned roll;
    if (gap_pct != 0 && $urandom_range(19) == 0) settle();
    if ($urandom_range(99) < 15) begin
      send_req(srlm_pkg::action_e'($urandom_range(1)), any_sample(), any_sample(),
               any_sample());
      return;
    end
    send_req(srlm_pkg::ACT_START, any_sample(), any_sample(), any_sample());
    if (tracker.regs.trig_en) begin
      repeat ($urandom_range(4)) begin
        send_req(srlm_pkg::ACT_TICK, any_sample(), pick_trig(0), pick_key(0));
      end
      if ($urandom_range(19) == 0) begin
        send_req(srlm_pkg::ACT_TICK, any_sample(), pick_trig(0), pick_key(1));
        return;
      end
      send_req(srlm_pkg::ACT_TICK, any_sample(), pick_trig(1), any_sample());
    end
    repeat ($urandom_range(12)) begin
      send_req(srlm_pkg::ACT_TICK, pick_resp(0), any_sample(), pick_key(0));
    end
    roll = $urandom_range(9);
    if (roll < 8) send_req(srlm_pkg::ACT_TICK, pick_resp(1), any_sample(), any_sample());
    else if (roll == 8) send_req(srlm_pkg::ACT_TICK, pick_resp(0), any_sample(), pick_key(1));
    else send_req(srlm_pkg::ACT_START, any_sample(), any_sample(), any_sample());
  endtask

  initial begin
    int unsigned random_goal;
    int unsigned steady_goal;
    int unsigned phase_end;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    action       = srlm_pkg::ACT_TICK;
    sensor       = '0;
    trigger      = '0;
    key_lvl      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = srlm_pkg::CFG_RESP_THR;
    cfg_data     = '0;
    gap_pct      = IDLE_PCT;
    rx_steady    = 1'b0;
    n_items      = 0;
    tracker      = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset settings: falling, thr 512, key 1000, 64 us ---
    send_req(srlm_pkg::ACT_TICK, '0, '1, '0);             // tick before any start: ignored
    send_req(srlm_pkg::ACT_START, '1, '1, '1);
    send_req(srlm_pkg::ACT_TICK, 10'd512, '0, 10'd1000);  // on threshold: no crossing
    send_req(srlm_pkg::ACT_TICK, '1, '1, '1);
    send_req(srlm_pkg::ACT_TICK, 10'd511, '0, '0);        // crossing wins over abort
    send_req(srlm_pkg::ACT_TICK, '0, '0, '0);             // tick after finishing: ignored
    send_req(srlm_pkg::ACT_START, '0, '0, '0);
    send_req(srlm_pkg::ACT_TICK, '1, '0, 10'd999);        // key abort
    send_req(srlm_pkg::ACT_START, '0, '0, '0);
    send_req(srlm_pkg::ACT_TICK, 10'd600, '0, '1);
    send_req(srlm_pkg::ACT_START, '1, '1, '1);            // restart while measuring
    send_req(srlm_pkg::ACT_TICK, '0, '1, '1);

    // trigger wait, rising polarity, zero tick length
    settle();
    write_reg(srlm_pkg::CFG_RISING, 10'd1);
    write_reg(srlm_pkg::CFG_TRIG_EN, 10'd1);
    write_reg(srlm_pkg::CFG_RESP_THR, 10'd0);
    write_reg(srlm_pkg::CFG_KEY_THR, 10'd0);
    write_reg(srlm_pkg::CFG_TICK_US, 10'd0);
    send_req(srlm_pkg::ACT_START, '0, '0, '0);
    send_req(srlm_pkg::ACT_TICK, '1, 10'd512, '0);        // trigger on threshold: not armed
    send_req(srlm_pkg::ACT_TICK, '0, 10'd513, '0);        // armed, count restarts
    send_req(srlm_pkg::ACT_TICK, '0, '0, '0);             // equal to threshold: no crossing
    send_req(srlm_pkg::ACT_TICK, 10'd1, '0, '0);          // crossing, measured with zero tick length

    // abort in the trigger wait, largest tick length
    settle();
    write_reg(srlm_pkg::CFG_KEY_THR, 10'd1023);
    write_reg(srlm_pkg::CFG_TICK_US, 10'd255);
    send_req(srlm_pkg::ACT_START, '0, '0, '0);
    send_req(srlm_pkg::ACT_TICK, '1, '0, 10'd1022);       // abort before arming
    send_req(srlm_pkg::ACT_START, '0, '0, '0);
    send_req(srlm_pkg::ACT_TICK, '0, '1, '0);             // arming wins over abort
    send_req(srlm_pkg::ACT_TICK, '1, '0, '1);

    settle();
    write_reg(srlm_pkg::CFG_TRIG_EN, 10'd0);
    write_reg(srlm_pkg::CFG_RISING, 10'd0);
    write_reg(srlm_pkg::CFG_RESP_THR, 10'd1023);
    send_req(srlm_pkg::ACT_START, '0, '0, '0);
    send_req(srlm_pkg::ACT_TICK, 10'd1022, '0, '1);

    // --- steady stretch, no idling on either side ---
    settle();
    random_config();
    gap_pct     = 0;
    rx_steady   = 1'b1;
    steady_goal = n_items + STEADY_ITEMS;
    while (n_items < steady_goal) run_sequence();
    settle();
    gap_pct   = IDLE_PCT;
    rx_steady = 1'b0;

    // --- random: a new register setting every few dozen requests ---
    random_goal = n_items + RANDOM_ITEMS;
    while (n_items < random_goal) begin
      settle();
      random_config();
      phase_end = n_items + $urandom_range(90, 40);
      while (n_items < phase_end && n_items < random_goal) run_sequence();
    end

    settle();
    repeat (PIPE_CYCLES * 2) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
